// ----- rtl/wgm_pkg.sv -----
// Package for the wildcard glob matcher.
// Sizes, opcodes and the structs passed between the top level and its cells.
// No dependencies.
package wgm_pkg;

  localparam int unsigned PATTERN_MAX = 32;
  localparam int unsigned LEN_W       = $clog2(PATTERN_MAX + 1);
  localparam int unsigned CHAR_W      = 8;

  localparam logic [CHAR_W-1:0] STAR_CHAR    = 8'h2A;
  localparam logic [CHAR_W-1:0] WILDCARD_RST = 8'h3F;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_END    = 2'd3
  } wgm_op_e;

  // broadcast to every cell
  typedef struct packed {
    logic              fire;
    wgm_op_e           op;
    logic [CHAR_W-1:0] ch;
    logic [CHAR_W-1:0] wild;
  } cell_cmd_t;

  // per-cell control from the top level
  typedef struct packed {
    logic wr_en;
    logic in_use;
    logic is_head;
  } cell_ctl_t;

  // neighbour link: star closure carry and text advance
  typedef struct packed {
    logic close;
    logic adv;
  } cell_link_t;

endpackage

// ----- rtl/wgm_intf.sv -----
// Channel interfaces of the wildcard glob matcher: input, result and config.
// Depends on wgm_pkg for field widths.
interface wgm_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 opcode;
  logic [wgm_pkg::CHAR_W-1:0] char_code;
  modport source (output valid, output opcode, output char_code, input ready);
  modport sink   (input valid, input opcode, input char_code, output ready);
endinterface

interface wgm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic status;
  modport source (output valid, output matched, output status, input ready);
  modport sink   (input valid, input matched, input status, output ready);
endinterface

interface wgm_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [wgm_pkg::CHAR_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/wildcard_glob_matcher.sv -----
// Top level of the wildcard glob matcher: a row of pattern cells and the result stage.
// Depends on wgm_pkg, the interfaces in wgm_intf and wgm_cell.
//
// Usage
// - in_i carries one command per beat: opcode 0 clears the pattern, 1 appends
//   char_code to it, 2 feeds char_code as a text character, 3 ends the text.
// - Only an end-of-text beat yields a result on out_o: matched, and status
//   (1 when the pattern overflowed its 32 entries; matched is then 0).
// - cfg_i writes the single-character wildcard code (reset '?') and is always ready;
//   the user must write it only while the block is idle; the block never enforces it.
// Timing
// - A beat can be taken in every cycle while in_i.ready is high.
// - A result shows on out_o the cycle after its end-of-text beat and holds
//   until out_o.ready. The one-entry output register sets the rate: in_i.ready
//   drops only while a result is held and out_o.ready is low.
// - All positions step at once; star closure ripples through the cell row in
//   the same cycle, so the row length sets the critical path.
// Reset
// - Clears the pattern length, the overflow flag and the output valid flag,
//   leaves only position zero active and restores the wildcard to '?'.
//   Stored pattern characters are not cleared.
module wildcard_glob_matcher (
  input  logic      clk_i,
  input  logic      rst_ni,
  wgm_in_if.sink    in_i,
  wgm_out_if.source out_o,
  wgm_cfg_if.sink   cfg_i
);

  localparam int unsigned MAX = wgm_pkg::PATTERN_MAX;
  localparam int unsigned LW  = wgm_pkg::LEN_W;

  logic [LW-1:0]              len_q, len_d;
  logic                       ovf_q, ovf_d;
  logic [wgm_pkg::CHAR_W-1:0] wild_q;
  logic                       tail_q, tail_d;   // position just past the last cell
  logic                       out_valid_q, out_matched_q, out_status_q;

  logic                 fire;
  wgm_pkg::cell_cmd_t   cmd;
  wgm_pkg::cell_ctl_t   ctl  [MAX];
  wgm_pkg::cell_link_t  link [MAX+1];
  logic [MAX:0]         closed;

  // Handshakes: a held result only blocks input when the sink stalls.
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign fire        = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign cmd.fire = fire;
  assign cmd.op   = wgm_pkg::wgm_op_e'(in_i.opcode);
  assign cmd.ch   = in_i.char_code;
  assign cmd.wild = wild_q;

  assign link[0] = '0;

  // Cell row: each cell hands closure carry and text advance to the next.
  for (genvar i = 0; i < MAX; i++) begin : g_cell
    assign ctl[i].wr_en   = fire && (cmd.op == wgm_pkg::OP_APPEND) &&
                            (len_q == LW'(i));
    assign ctl[i].in_use  = (len_q > LW'(i));
    assign ctl[i].is_head = (i == 0);

    wgm_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (cmd),
      .ctl_i    (ctl[i]),
      .link_i   (link[i]),
      .link_o   (link[i+1]),
      .closed_o (closed[i])
    );
  end

  // Final position has no character: it only collects carry and advance.
  assign closed[MAX] = tail_q | link[MAX].close;

  always_comb begin
    len_d  = len_q;
    ovf_d  = ovf_q;
    tail_d = tail_q;
    if (fire) begin
      unique case (cmd.op)
        wgm_pkg::OP_CLEAR: begin
          len_d  = '0;
          ovf_d  = 1'b0;
          tail_d = 1'b0;
        end
        wgm_pkg::OP_APPEND: begin
          if (len_q < LW'(MAX)) begin
            len_d = len_q + LW'(1);
          end else begin
            ovf_d = 1'b1;   // character dropped, flag sticks until clear
          end
        end
        wgm_pkg::OP_TEXT: tail_d = link[MAX].adv;
        wgm_pkg::OP_END:  tail_d = 1'b0;
        default:          tail_d = tail_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      ovf_q       <= 1'b0;
      tail_q      <= 1'b0;
      wild_q      <= wgm_pkg::WILDCARD_RST;
      out_valid_q <= 1'b0;
    end else begin
      len_q  <= len_d;
      ovf_q  <= ovf_d;
      tail_q <= tail_d;
      if (cfg_i.valid) begin
        wild_q <= cfg_i.data;
      end
      if (fire && (cmd.op == wgm_pkg::OP_END)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: the closed set at the pattern length, masked on overflow.
  always_ff @(posedge clk_i) begin
    if (fire && (cmd.op == wgm_pkg::OP_END)) begin
      out_matched_q <= !ovf_q && closed[len_q];
      out_status_q  <= ovf_q;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.matched = out_matched_q;
  assign out_o.status  = out_status_q;

endmodule

// ----- rtl/wgm_cell.sv -----
// One pattern position of the glob matcher: stored character and active flag.
// Depends on wgm_pkg.
module wgm_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wgm_pkg::cell_cmd_t         cmd_i,
  input  wgm_pkg::cell_ctl_t         ctl_i,
  input  wgm_pkg::cell_link_t        link_i,
  output wgm_pkg::cell_link_t        link_o,
  output logic                       closed_o
);

  logic [wgm_pkg::CHAR_W-1:0] char_q;
  // stored relative to is_head so that reset leaves the head cell active
  logic act_q, act_d;
  logic act, act_next;
  logic is_star, is_lit, closed;

  assign act     = act_q ^ ctl_i.is_head;
  assign is_star = ctl_i.in_use && (char_q == wgm_pkg::STAR_CHAR);
  assign is_lit  = ctl_i.in_use && (char_q != wgm_pkg::STAR_CHAR) &&
                   ((char_q == cmd_i.ch) || (char_q == cmd_i.wild));

  assign closed      = act | link_i.close;
  assign link_o.close = closed & is_star;
  assign link_o.adv   = closed & is_lit;
  assign closed_o     = closed;

  always_comb begin
    act_next = act;
    if (cmd_i.fire) begin
      unique case (cmd_i.op)
        wgm_pkg::OP_CLEAR,
        wgm_pkg::OP_END:    act_next = ctl_i.is_head;
        wgm_pkg::OP_TEXT:   act_next = (closed & is_star) | link_i.adv;
        wgm_pkg::OP_APPEND: act_next = act;
        default:            act_next = act;
      endcase
    end
    act_d = act_next ^ ctl_i.is_head;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else begin
      act_q <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      char_q <= cmd_i.ch;
    end
  end

endmodule

// ----- rtl/wgm_checker.sv -----
// Port-level checks for the wildcard glob matcher, bound to the top level.
// Depends on wgm_pkg and wildcard_glob_matcher.
module wgm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [1:0] in_opcode_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_matched_i,
  input logic       out_status_i
);

  logic in_beat;
  assign in_beat = in_valid_i && in_ready_i;

  // an end-of-text beat yields a result in the next cycle
  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && (in_opcode_i == wgm_pkg::OP_END)) |=> out_valid_i)
    else $error("end-of-text beat gave no result");

  // other commands yield nothing once the held result has gone
  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && (in_opcode_i != wgm_pkg::OP_END) && (!out_valid_i || out_ready_i))
    |=> !out_valid_i)
    else $error("result without end-of-text beat");

  // overflow status forces no match
  a_overflow_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(out_matched_i && out_status_i))
    else $error("match reported with overflow status");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_matched_i) && $stable(out_status_i)))
    else $error("stalled result changed");

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_opcode_i   (in_i.opcode),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_matched_i (out_o.matched),
  .out_status_i  (out_o.status)
);
